FILE: rtl/rdd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rdd_pkg;

  localparam int unsigned MAX_DIGITS_DEF = 16;

  localparam logic [1:0] OP_DIAL_EN = 2'd0;
  localparam logic [1:0] OP_PULSE   = 2'd1;
  localparam logic [1:0] OP_BUTTON  = 2'd2;
  localparam logic [1:0] OP_HOOK    = 2'd3;

  localparam logic [1:0] KIND_DIAL  = 2'd0;
  localparam logic [1:0] KIND_NUM   = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;
  localparam logic [1:0] KIND_HOOK  = 2'd3;

  localparam logic [19:0] GAP_RESET = 20'd10000;
  localparam logic [3:0]  DIAL_BASE = 4'd10;

  typedef struct packed {
    logic cap;
    logic stamp_wr;
    logic pulse_clr;
    logic pulse_inc;
    logic dial;
    logic empty;
    logic hook;
    logic rd_clr;
    logic rd_load;
    logic num_clr;
  } rdd_cmd_t;

  typedef struct packed {
    logic       accepted;
    logic [1:0] opcode;
    logic       level;
    logic       total_zero;
    logic       last;
  } rdd_sts_t;

endpackage

`default_nettype wire

FILE: rtl/rdd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rdd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic        level;
  logic [31:0] tick;

  modport source(output valid, output opcode, output level, output tick, input ready);
  modport sink(input valid, input opcode, input level, input tick, output ready);
endinterface

`default_nettype wire

FILE: rtl/rdd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rdd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] digit;
  logic       hook_state;
  logic       overflow;
  logic       last;

  modport source(output valid, output kind, output digit, output hook_state,
                 output overflow, output last, input ready);
  modport sink(input valid, input kind, input digit, input hook_state,
               input overflow, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/rdd_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rdd_cfg_if;
  logic        valid;
  logic        ready;
  logic [19:0] data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/rdd_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module rdd_dp
  import rdd_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire rdd_cmd_t    cmd_i,
  output rdd_sts_t         sts_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic        level_i,
  input  wire logic [31:0] tick_i,
  input  wire logic        cfg_we_i,
  input  wire logic [19:0] cfg_data_i,
  output logic [1:0]       kind_o,
  output logic [3:0]       digit_o,
  output logic             hook_state_o,
  output logic             overflow_o,
  output logic             last_o
);

  localparam int unsigned CW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic [1:0]    op_q;
  logic          level_q;
  logic [31:0]   tick_q;
  logic [19:0]   gap_q;
  logic [31:0]   stamp_q [4];
  logic [3:0]    pulse_q;
  logic [CW-1:0] total_q;
  logic [CW-1:0] cnt_q;
  logic          drop_q;
  logic          hook_q;
  logic [3:0]    mem_q [MAX_DIGITS];
  logic [3:0]    rdata_q;
  logic [1:0]    kind_q;
  logic [3:0]    digit_q;
  logic          hook_st_q;
  logic          ovf_q;
  logic          last_q;

  logic [31:0]   diff;
  logic          full;
  logic [CW-1:0] cnt_inc;

  assign diff    = tick_q - stamp_q[op_q];
  assign full    = (total_q == CW'(MAX_DIGITS));
  assign cnt_inc = CW'(cnt_q + 1'b1);

  assign sts_o.accepted   = (diff > {12'd0, gap_q});
  assign sts_o.opcode     = op_q;
  assign sts_o.level      = level_q;
  assign sts_o.total_zero = (total_q == '0);
  assign sts_o.last       = last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q    <= opcode_i;
      level_q <= level_i;
      tick_q  <= tick_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q   <= GAP_RESET;
      stamp_q <= '{default: '0};
      pulse_q <= '0;
      total_q <= '0;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      hook_q  <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        gap_q <= cfg_data_i;
      end
      if (cmd_i.stamp_wr) begin
        stamp_q[op_q] <= tick_q;
      end
      if (cmd_i.pulse_clr) begin
        pulse_q <= '0;
      end else if (cmd_i.pulse_inc) begin
        pulse_q <= (pulse_q == DIAL_BASE - 4'd1) ? 4'd0 : pulse_q + 4'd1;
      end
      if (cmd_i.dial) begin
        if (full) begin
          drop_q <= 1'b1;
        end else begin
          total_q <= CW'(total_q + 1'b1);
        end
      end
      if (cmd_i.num_clr) begin
        total_q <= '0;
        drop_q  <= 1'b0;
      end
      if (cmd_i.rd_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.rd_load) begin
        cnt_q <= cnt_inc;
      end
      if (cmd_i.hook) begin
        hook_q <= level_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dial && !full) begin
      mem_q[total_q[AW-1:0]] <= pulse_q;
    end
    rdata_q <= mem_q[cnt_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dial) begin
      kind_q    <= KIND_DIAL;
      digit_q   <= pulse_q;
      hook_st_q <= hook_q;
      ovf_q     <= full | drop_q;
      last_q    <= 1'b1;
    end else if (cmd_i.empty) begin
      kind_q    <= KIND_EMPTY;
      digit_q   <= '0;
      hook_st_q <= hook_q;
      ovf_q     <= drop_q;
      last_q    <= 1'b1;
    end else if (cmd_i.hook) begin
      kind_q    <= KIND_HOOK;
      digit_q   <= '0;
      hook_st_q <= level_q;
      ovf_q     <= drop_q;
      last_q    <= 1'b1;
    end else if (cmd_i.rd_load) begin
      kind_q    <= KIND_NUM;
      digit_q   <= rdata_q;
      hook_st_q <= hook_q;
      ovf_q     <= drop_q;
      last_q    <= (cnt_inc == total_q);
    end
  end

  assign kind_o       = kind_q;
  assign digit_o      = digit_q;
  assign hook_state_o = hook_st_q;
  assign overflow_o   = ovf_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

FILE: rtl/rdd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rdd_ctrl
  import rdd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     evt_valid_i,
  output logic          evt_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire rdd_sts_t sts_i,
  output rdd_cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_OUT   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_LD    = 3'd4;
  localparam logic [2:0] S_BOUT  = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;

  assign evt_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT) || (state_q == S_BOUT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (evt_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.stamp_wr = 1'b1;
        state_d        = S_IDLE;
        if (sts_i.accepted) begin
          case (sts_i.opcode)
            OP_DIAL_EN: begin
              if (sts_i.level) begin
                cmd_o.dial = 1'b1;
                state_d    = S_OUT;
              end else begin
                cmd_o.pulse_clr = 1'b1;
              end
            end
            OP_PULSE: begin
              cmd_o.pulse_inc = sts_i.level;
            end
            OP_BUTTON: begin
              if (sts_i.level) begin
                if (sts_i.total_zero) begin
                  cmd_o.empty   = 1'b1;
                  cmd_o.num_clr = 1'b1;
                  state_d       = S_OUT;
                end else begin
                  cmd_o.rd_clr = 1'b1;
                  state_d      = S_RD;
                end
              end
            end
            OP_HOOK: begin
              cmd_o.hook = 1'b1;
              state_d    = S_OUT;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        state_d = S_LD;
      end
      S_LD: begin
        cmd_o.rd_load = 1'b1;
        state_d       = S_BOUT;
      end
      S_BOUT: begin
        if (out_ready_i) begin
          if (sts_i.last) begin
            cmd_o.num_clr = 1'b1;
            state_d       = S_IDLE;
          end else begin
            state_d = S_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rotary_dial_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Beat contents
// evt_i     in         opcode, level, tick of one debounced input edge
// res_o     out        kind, digit, hook_state, overflow, last
// cfg_i     in         debounce gap in microseconds (20 bits)
//
// An event is captured in S_IDLE and checked in S_CHECK; a dial, hook or empty-number
// result then waits in the output register until its beat is taken.
// A button run steps each stored digit through S_RD, S_LD and S_BOUT, as the digit
// memory has a registered read; each digit beat waits in S_BOUT until it is taken.
// No new event is taken until the last result beat of the current one is gone.
// Reset needs no clearing pass; the configuration port is always ready.

module rotary_dial_decoder
  import rdd_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  rdd_in_if.sink   evt_i,
  rdd_out_if.source res_o,
  rdd_cfg_if.sink  cfg_i
);

  rdd_cmd_t cmd;
  rdd_sts_t sts;

  assign cfg_i.ready = 1'b1;

  rdd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_valid_i (evt_i.valid),
    .evt_ready_o (evt_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rdd_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .opcode_i     (evt_i.opcode),
    .level_i      (evt_i.level),
    .tick_i       (evt_i.tick),
    .cfg_we_i     (cfg_i.valid),
    .cfg_data_i   (cfg_i.data),
    .kind_o       (res_o.kind),
    .digit_o      (res_o.digit),
    .hook_state_o (res_o.hook_state),
    .overflow_o   (res_o.overflow),
    .last_o       (res_o.last)
  );

  a_no_evt_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !evt_i.ready)
    else $error("event taken while a result is pending");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.kind != KIND_NUM) |-> res_o.last)
    else $error("single result without last");

  a_digit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.kind == KIND_EMPTY || res_o.kind == KIND_HOOK))
      |-> (res_o.digit == 4'd0))
    else $error("nonzero digit on hook or empty result");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.ready && res_o.last) |=> (!res_o.valid && evt_i.ready))
    else $error("block not idle after final beat");

endmodule

`default_nettype wire

FILE: tb/dial_result_checker.sv
`timescale 1ns / 1ps

module dial_result_checker
  import rdd_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  rdd_in_if           evt_i,
  rdd_out_if          res_i,
  rdd_cfg_if          cfg_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] digit;
    logic       hook_state;
    logic       overflow;
    logic       last;
  } dial_result_t;

  logic [19:0]  gap_us;
  logic [31:0]  last_tick [4];
  logic [3:0]   pulse_count;
  logic [3:0]   number [MAX_DIGITS];
  int unsigned  number_len;
  logic         dropped;
  logic         on_hook;
  dial_result_t expected_q [$];

  task automatic push_result(input logic [1:0] kind, input logic [3:0] digit,
                             input logic last);
    dial_result_t r;
    r = '{kind, digit, on_hook, dropped, last};
    expected_q.push_back(r);
  endtask

  task automatic predict_event(input logic [1:0] op, input logic level,
                               input logic [31:0] tick);
    logic [31:0] since;
    since = tick - last_tick[op];
    last_tick[op] = tick;
    if (since <= {12'd0, gap_us}) return;
    case (op)
      OP_DIAL_EN: begin
        if (level) begin
          if (number_len < MAX_DIGITS) begin
            number[number_len] = pulse_count;
            number_len++;
          end else begin
            dropped = 1'b1;
          end
          push_result(KIND_DIAL, pulse_count, 1'b1);
        end else begin
          pulse_count = '0;
        end
      end
      OP_PULSE: begin
        if (level) begin
          pulse_count = (pulse_count == DIAL_BASE - 4'd1) ? 4'd0 : pulse_count + 4'd1;
        end
      end
      OP_BUTTON: begin
        if (level) begin
          if (number_len == 0) begin
            push_result(KIND_EMPTY, 4'd0, 1'b1);
          end else begin
            for (int i = 0; i < number_len; i++) begin
              push_result(KIND_NUM, number[i], (i + 1 == number_len));
            end
          end
          number_len = 0;
          dropped = 1'b0;
        end
      end
      default: begin
        on_hook = level;
        push_result(KIND_HOOK, 4'd0, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dial_result_t seen;
    dial_result_t want;
    if (!rst_ni) begin
      gap_us = GAP_RESET;
      foreach (last_tick[i]) last_tick[i] = '0;
      pulse_count = '0;
      number_len = 0;
      dropped = 1'b0;
      on_hook = 1'b1;
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        seen = '{res_i.kind, res_i.digit, res_i.hook_state, res_i.overflow, res_i.last};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat, got kind %0d digit %0d hook %0b ovf %0b last %0b",
                   $time, seen.kind, seen.digit, seen.hook_state, seen.overflow, seen.last);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (seen.kind !== want.kind || seen.digit !== want.digit ||
              seen.hook_state !== want.hook_state || seen.overflow !== want.overflow ||
              seen.last !== want.last) begin
            $display("%0t: expected kind %0d digit %0d hook %0b ovf %0b last %0b",
                     $time, want.kind, want.digit, want.hook_state, want.overflow, want.last);
            $display("%0t:      got kind %0d digit %0d hook %0b ovf %0b last %0b",
                     $time, seen.kind, seen.digit, seen.hook_state, seen.overflow, seen.last);
            fail_count_o++;
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        gap_us = cfg_i.data;
      end
      if (evt_i.valid && evt_i.ready) begin
        predict_event(evt_i.opcode, evt_i.level, evt_i.tick);
      end
    end
    pending_o = expected_q.size();
  end

endmodule

FILE: tb/tb_rotary_dial_decoder.sv
`timescale 1ns / 1ps

module tb_rotary_dial_decoder;
  import rdd_pkg::*;

  localparam int unsigned MAX_DIGITS   = MAX_DIGITS_DEF;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned DRAIN_CYCLES = 3 * MAX_DIGITS + 10;
  localparam int unsigned PHASE_ITEMS  = 4;

  logic        clk_i;
  logic        rst_ni;
  int unsigned pending;
  int unsigned fails;
  int unsigned sent;
  int unsigned gap_now;
  logic [31:0] prev_tick [4];
  bit          steady;

  rdd_in_if  evt ();
  rdd_out_if res ();
  rdd_cfg_if cfg ();

  rotary_dial_decoder #(.MAX_DIGITS(MAX_DIGITS)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .evt_i (evt),
    .res_o (res),
    .cfg_i (cfg)
  );

  dial_result_checker #(.MAX_DIGITS(MAX_DIGITS)) result_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_i       (evt),
    .res_i       (res),
    .cfg_i       (cfg),
    .pending_o   (pending),
    .fail_count_o(fails)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic bit take_break();
    return !steady && ($urandom_range(0, 99) < 14);
  endfunction

  function automatic logic [31:0] tick_step(input bit bounce);
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (bounce) begin
      return (pick < 4) ? 32'(gap_now) : 32'($urandom_range(0, gap_now));
    end
    if (pick == 0) return 32'(gap_now) + 32'd1;
    if (pick == 1) return $urandom();
    return 32'(gap_now) + 32'd1 + 32'($urandom_range(0, 5000));
  endfunction

  always @(negedge clk_i) begin
    res.ready <= steady || ($urandom_range(0, 99) >= 14);
  end

  task automatic post_at(input logic [1:0] op, input logic level, input logic [31:0] tick);
    while (take_break()) begin
      evt.valid <= 1'b0;
      @(negedge clk_i);
    end
    evt.valid  <= 1'b1;
    evt.opcode <= op;
    evt.level  <= level;
    evt.tick   <= tick;
    @(posedge clk_i);
    while (!evt.ready) @(posedge clk_i);
    @(negedge clk_i);
    prev_tick[op] = tick;
    sent++;
  endtask

  task automatic post_after(input logic [1:0] op, input logic level, input bit bounce);
    post_at(op, level, prev_tick[op] + tick_step(bounce));
  endtask

  task automatic dial_digit(input int unsigned pulses);
    post_after(OP_DIAL_EN, 1'b0, 1'b0);
    repeat (pulses) begin
      post_after(OP_PULSE, 1'b1, 1'b0);
      if ($urandom_range(0, 9) == 0) post_after(OP_PULSE, 1'b1, 1'b1);
      if ($urandom_range(0, 2) == 0) post_after(OP_PULSE, 1'b0, 1'b0);
    end
    post_after(OP_DIAL_EN, 1'b1, 1'b0);
  endtask

  task automatic press_button();
    post_after(OP_BUTTON, 1'b1, 1'b0);
    if ($urandom_range(0, 1) == 1) post_after(OP_BUTTON, 1'b0, 1'b0);
  endtask

  task automatic random_traffic(input int unsigned items);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = sent + items;
    while (sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        dial_digit($urandom_range(0, 12));
      end else if (pick < 65) begin
        press_button();
      end else if (pick < 80) begin
        post_after(OP_HOOK, 1'($urandom_range(0, 1)), 1'b0);
      end else if (pick < 90) begin
        post_after(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 1'b1);
      end else begin
        post_at(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom());
      end
    end
  endtask

  task automatic settle();
    evt.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_gap(input logic [19:0] gap);
    cfg.valid <= 1'b1;
    cfg.data  <= gap;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg.valid <= 1'b0;
    gap_now = gap;
  endtask

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((evt.valid && evt.ready) || (res.valid && res.ready) ||
          (cfg.valid && cfg.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_ni     = 1'b0;
    evt.valid  = 1'b0;
    evt.opcode = OP_DIAL_EN;
    evt.level  = 1'b0;
    evt.tick   = '0;
    res.ready  = 1'b0;
    cfg.valid  = 1'b0;
    cfg.data   = '0;
    steady     = 1'b0;
    sent       = 0;
    gap_now    = GAP_RESET;
    foreach (prev_tick[i]) prev_tick[i] = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    post_at(OP_HOOK, 1'b0, 32'd10001);
    post_at(OP_HOOK, 1'b1, 32'd20001);
    post_at(OP_HOOK, 1'b1, 32'd30002);
    post_at(OP_HOOK, 1'b1, 32'd40003);
    post_at(OP_BUTTON, 1'b1, 32'd10001);
    post_at(OP_BUTTON, 1'b0, 32'd20002);
    post_at(OP_DIAL_EN, 1'b0, 32'd10001);
    for (int k = 1; k <= 11; k++) begin
      post_at(OP_PULSE, 1'b1, 32'(k * 10001));
    end
    post_at(OP_PULSE, 1'b0, 32'(12 * 10001));
    post_at(OP_DIAL_EN, 1'b1, 32'd20002);
    post_at(OP_BUTTON, 1'b1, 32'd30003);
    post_at(OP_DIAL_EN, 1'b0, 32'hFFFF_FFFF);
    post_at(OP_DIAL_EN, 1'b1, 32'h0000_2000);
    post_at(OP_DIAL_EN, 1'b1, 32'h0000_2000 + 32'd10001);
    post_at(OP_BUTTON, 1'b1, 32'd40004);
    settle();

    set_gap(20'd0);
    random_traffic(PHASE_ITEMS);
    repeat (17) dial_digit($urandom_range(0, 1));
    post_after(OP_BUTTON, 1'b1, 1'b0);
    settle();

    set_gap(20'd1000000);
    steady = 1'b1;
    random_traffic(PHASE_ITEMS);
    settle();
    steady = 1'b0;

    set_gap(20'($urandom_range(1, 999999)));
    random_traffic(PHASE_ITEMS);
    settle();

    set_gap(20'($urandom_range(0, 1000)));
    random_traffic(PHASE_ITEMS);
    settle();

    set_gap(GAP_RESET);
    random_traffic(PHASE_ITEMS);
    settle();

    if (fails == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
